>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sprpg_pkg.sv
// ----------------------------------------------------------------------------
// sprpg_pkg
// Types, codes and constants shared by the servo ramp and power gate block.
// ----------------------------------------------------------------------------
package sprpg_pkg;

	// Field widths.
	localparam int POS_W   = 12;
	localparam int LVL_W   = 7;
	localparam int TRANS_W = 16;
	localparam int CMD_W   = 2;
	localparam int CL_W    = 8;
	localparam int REG_W   = 1;

	// Packed stream widths.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// Divider and multiplier sizes.
	localparam int NUM_W  = 28;
	localparam int DEN_W  = 16;
	localparam int PROD_W = POS_W + TRANS_W + 2;

	// Reset values and fixed numbers.
	localparam logic [POS_W-1:0] CLOSED_RST = 12'd1000;
	localparam logic [POS_W-1:0] OPEN_RST   = 12'd2000;
	localparam int POWER_OFF_TICKS_DEF      = 500;
	localparam int PCT                      = 100;
	localparam logic [LVL_W-1:0] LEVEL_FULL = 7'd100;
	localparam logic signed [CL_W-1:0] LEVEL_UNKNOWN = -8'sd1;

	// Request commands.
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_CLOSED = 1'b0;
	localparam logic [REG_W-1:0] REG_OPEN   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic tick_jump;
		logic tick_step;
		logic tick_idle;
		logic set_open;
		logic set_mul;
		logic restart;
		logic apply_ramp;
		logic apply_set;
		logic lvl_mul;
		logic lvl_apply;
		logic lvl_plain;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic moving;
		logic level_eq;
		logic level_ge_full;
		logic ramp_done;
		logic range_zero;
		logic div_done;
	} dp_stat_t;

endpackage

>>> design/sprpg_div.sv
// ----------------------------------------------------------------------------
// sprpg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sprpg_div #(
	parameter int NW = sprpg_pkg::NUM_W,
	parameter int DW = sprpg_pkg::DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	import sprpg_pkg::*;

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// Step counter and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> design/sprpg_dpath.sv
// ----------------------------------------------------------------------------
// sprpg_dpath
// Position, target, ramp and power registers with the shared multiplier and
// divider that serve the ramp step, the level mapping and the level report.
// ----------------------------------------------------------------------------
module sprpg_dpath #(
	parameter int POWER_OFF_TICKS = sprpg_pkg::POWER_OFF_TICKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sprpg_pkg::REG_W-1:0]         cfg_addr,
	input  logic [sprpg_pkg::POS_W-1:0]         cfg_data,
	input  logic [sprpg_pkg::CMD_W-1:0]         in_cmd,
	input  logic [sprpg_pkg::LVL_W-1:0]         in_level,
	input  logic [sprpg_pkg::TRANS_W-1:0]       in_trans,
	input  sprpg_pkg::dp_cmd_t                  cmd,
	output sprpg_pkg::dp_stat_t                 stat,
	output logic [sprpg_pkg::POS_W-1:0]         out_position,
	output logic                                out_power,
	output logic                                out_moving,
	output logic signed [sprpg_pkg::CL_W-1:0]   out_level
);
	import sprpg_pkg::*;

	localparam int CD_W = $clog2(POWER_OFF_TICKS + 2);
	localparam logic [CD_W-1:0] CD_ARM = CD_W'(POWER_OFF_TICKS + 1);
	localparam int QS_W = NUM_W + 2;

	// Configuration and state.
	logic [POS_W-1:0]          closed_q, open_q;
	logic [POS_W-1:0]          cur_q, origin_q, tgt_q;
	logic [TRANS_W-1:0]        elapsed_q, ramp_q;
	logic signed [CL_W-1:0]    req_q;
	logic [CD_W-1:0]           cd_q;
	logic                      power_q;
	logic signed [CL_W-1:0]    lvl_q;

	// Latched request.
	logic [CMD_W-1:0]          cmd_q;
	logic [LVL_W-1:0]          level_q;
	logic [TRANS_W-1:0]        trans_q;

	// Multiplier and divider operands.
	logic signed [POS_W:0]     mul_a;
	logic signed [TRANS_W:0]   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [DEN_W-1:0]          den_s1;
	logic                      den_neg_s1;
	logic                      floor_s1;
	logic                      start_s1;
	logic [PROD_W-1:0]         prod_neg;
	logic [NUM_W-1:0]          num_mag;
	logic                      div_done;
	logic [NUM_W-1:0]          quo;
	logic [DEN_W-1:0]          rem;

	// Derived values.
	logic [TRANS_W-1:0]        el_inc;
	logic signed [POS_W:0]     range;
	logic [POS_W:0]            range_neg;
	logic [POS_W-1:0]          range_mag;
	logic                      moving;
	logic                      neg_res;
	logic [QS_W-1:0]           q_ext;
	logic [QS_W-1:0]           q_sgn;
	logic signed [QS_W-1:0]    q_fix;
	logic [POS_W-1:0]          ramp_pos;
	logic signed [CL_W-1:0]    q_sat;

	assign moving    = (cur_q != tgt_q);
	assign el_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign range     = $signed({1'b0, open_q}) - $signed({1'b0, closed_q});
	assign range_neg = -range;
	assign range_mag = range[POS_W] ? range_neg[POS_W-1:0] : range[POS_W-1:0];

	// Status for the controller.
	always_comb begin
		stat.cmd           = cmd_q;
		stat.moving        = moving;
		stat.level_eq      = ($signed({1'b0, level_q}) == req_q);
		stat.level_ge_full = (level_q >= LEVEL_FULL);
		stat.ramp_done     = (ramp_q == '0) || (el_inc >= ramp_q);
		stat.range_zero    = (range == '0);
		stat.div_done      = div_done;
	end

	// Operand selection for the single multiplier.
	always_comb begin
		if (cmd.tick_step) begin
			mul_a = $signed({1'b0, tgt_q}) - $signed({1'b0, origin_q});
			mul_b = $signed({1'b0, el_inc});
		end else if (cmd.set_mul) begin
			mul_a = range;
			mul_b = $signed({{(TRANS_W + 1 - LVL_W){1'b0}}, level_q});
		end else begin
			mul_a = $signed({1'b0, cur_q}) - $signed({1'b0, closed_q});
			mul_b = (TRANS_W + 1)'(PCT);
		end
	end

	assign prod = mul_a * mul_b;

	// Product and divisor register; the divider starts in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= cmd.tick_step | cmd.set_mul | cmd.lvl_mul;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_step | cmd.set_mul | cmd.lvl_mul) begin
			prod_s1 <= prod;
			if (cmd.tick_step) begin
				den_s1     <= ramp_q;
				den_neg_s1 <= 1'b0;
				floor_s1   <= 1'b1;
			end else if (cmd.set_mul) begin
				den_s1     <= DEN_W'(PCT);
				den_neg_s1 <= 1'b0;
				floor_s1   <= 1'b1;
			end else begin
				den_s1     <= {{(DEN_W - POS_W){1'b0}}, range_mag};
				den_neg_s1 <= range[POS_W];
				floor_s1   <= 1'b0;
			end
		end
	end

	assign prod_neg = -prod_s1;
	assign num_mag  = prod_s1[PROD_W-1] ? prod_neg[NUM_W-1:0] : prod_s1[NUM_W-1:0];

	sprpg_div #(
		.NW (NUM_W),
		.DW (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_s1),
		.num    (num_mag),
		.den    (den_s1),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	// Signed quotient: floored for ramp and set, truncated for the report.
	assign neg_res = prod_s1[PROD_W-1] ^ den_neg_s1;
	assign q_ext   = {2'b00, quo};
	assign q_sgn   = neg_res ? -q_ext : q_ext;
	assign q_fix   = (floor_s1 && neg_res && (rem != '0)) ? $signed(q_sgn - 1'b1)
	                                                       : $signed(q_sgn);
	assign ramp_pos = origin_q + q_fix[POS_W-1:0];

	// Percentage saturated to the signed byte.
	always_comb begin
		if (q_fix > QS_W'(127)) begin
			q_sat = 8'sd127;
		end else if (q_fix < -QS_W'(128)) begin
			q_sat = -8'sd128;
		end else begin
			q_sat = q_fix[CL_W-1:0];
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= in_cmd;
			level_q <= in_level;
			trans_q <= in_trans;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= CLOSED_RST;
			open_q   <= OPEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CLOSED: closed_q <= cfg_data;
				REG_OPEN:   open_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ramp, target and power state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= CLOSED_RST + 1'b1;
			origin_q  <= CLOSED_RST + 1'b1;
			tgt_q     <= CLOSED_RST;
			elapsed_q <= '0;
			ramp_q    <= '0;
			req_q     <= LEVEL_UNKNOWN;
			cd_q      <= '0;
			power_q   <= 1'b0;
		end else if (cmd.restart) begin
			cur_q     <= closed_q + 1'b1;
			origin_q  <= closed_q + 1'b1;
			tgt_q     <= closed_q;
			elapsed_q <= '0;
			ramp_q    <= '0;
			req_q     <= LEVEL_UNKNOWN;
			cd_q      <= '0;
			power_q   <= 1'b0;
		end else if (cmd.tick_jump) begin
			cur_q     <= tgt_q;
			power_q   <= 1'b1;
			elapsed_q <= '0;
			ramp_q    <= '0;
			cd_q      <= CD_ARM;
		end else if (cmd.tick_step) begin
			elapsed_q <= el_inc;
		end else if (cmd.apply_ramp) begin
			cur_q   <= ramp_pos;
			power_q <= 1'b1;
			if (ramp_pos == tgt_q) begin
				elapsed_q <= '0;
				ramp_q    <= '0;
				cd_q      <= CD_ARM;
			end
		end else if (cmd.tick_idle) begin
			if (cd_q != '0) begin
				cd_q <= cd_q - 1'b1;
				if (cd_q == CD_W'(1)) begin
					power_q <= 1'b0;
				end
			end
		end else if (cmd.set_open || cmd.set_mul) begin
			req_q     <= $signed({1'b0, level_q});
			origin_q  <= cur_q;
			elapsed_q <= '0;
			ramp_q    <= trans_q;
			cd_q      <= '0;
			if (cmd.set_open) begin
				tgt_q <= open_q;
			end
		end else if (cmd.apply_set) begin
			tgt_q <= closed_q + q_fix[POS_W-1:0];
		end
	end

	// Reported level.
	always_ff @(posedge clk) begin
		if (cmd.lvl_apply) begin
			lvl_q <= q_sat;
		end else if (cmd.lvl_plain) begin
			lvl_q <= moving ? LEVEL_UNKNOWN : req_q;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_position <= cur_q;
			out_power    <= power_q;
			out_moving   <= moving;
			out_level    <= lvl_q;
		end
	end

endmodule

>>> design/sprpg_ctrl.sv
// ----------------------------------------------------------------------------
// sprpg_ctrl
// Sequencer: takes one request, steps the datapath through the command and
// the level report, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sprpg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  sprpg_pkg::dp_stat_t   stat,
	output sprpg_pkg::dp_cmd_t    cmd
);
	import sprpg_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DISPATCH  = 3'd1;
	localparam logic [2:0] ST_WAIT_RAMP = 3'd2;
	localparam logic [2:0] ST_WAIT_SET  = 3'd3;
	localparam logic [2:0] ST_LEVEL     = 3'd4;
	localparam logic [2:0] ST_WAIT_LVL  = 3'd5;
	localparam logic [2:0] ST_OUT       = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_LEVEL;
				case (stat.cmd)
					CMD_TICK: begin
						if (!stat.moving) begin
							cmd.tick_idle = 1'b1;
						end else if (stat.ramp_done) begin
							cmd.tick_jump = 1'b1;
						end else begin
							cmd.tick_step = 1'b1;
							state_d       = ST_WAIT_RAMP;
						end
					end
					CMD_SET: begin
						if (stat.level_eq) begin
							state_d = ST_LEVEL;
						end else if (stat.level_ge_full) begin
							cmd.set_open = 1'b1;
						end else begin
							cmd.set_mul = 1'b1;
							state_d     = ST_WAIT_SET;
						end
					end
					CMD_RESTART: begin
						cmd.restart = 1'b1;
					end
					default: ;
				endcase
			end
			ST_WAIT_RAMP: begin
				if (stat.div_done) begin
					cmd.apply_ramp = 1'b1;
					state_d        = ST_LEVEL;
				end
			end
			ST_WAIT_SET: begin
				if (stat.div_done) begin
					cmd.apply_set = 1'b1;
					state_d       = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (stat.moving && !stat.range_zero) begin
					cmd.lvl_mul = 1'b1;
					state_d     = ST_WAIT_LVL;
				end else begin
					cmd.lvl_plain = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_WAIT_LVL: begin
				if (stat.div_done) begin
					cmd.lvl_apply = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> design/servo_position_ramp_power_gate_core.sv
// ----------------------------------------------------------------------------
// servo_position_ramp_power_gate_core
// Servo opening controller: linear position ramp with delayed power-off.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the command (tick, set
// level, restart) and s_tdata the level and ramp length. Every request gives
// exactly one result on the m_ stream: position, power, moving flag and the
// reported percentage. closed_position and open_position are written through
// cfg_we, cfg_addr and cfg_data; the user must do so only while no request is
// in flight, since the block does not enforce it. One request is worked on at
// a time. A request that needs no division passes through the dispatch, level
// and output states. A ramp step or a level mapping adds one division (product
// register, divider start and one radix-2 step per quotient bit), and the
// percentage report while moving over a nonzero range adds another. That
// divider, shared by all three uses, sets the rate.
// After reset the registers hold 1000 and 2000, the position is one above
// closed, so the first tick drives the servo to closed, and power is off.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver holds only the following result back.
// ----------------------------------------------------------------------------
module servo_position_ramp_power_gate_core #(
	parameter int POWER_OFF_TICKS = sprpg_pkg::POWER_OFF_TICKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [sprpg_pkg::REG_W-1:0]        cfg_addr,
	input  logic [sprpg_pkg::POS_W-1:0]        cfg_data,
	// Request stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sprpg_pkg::S_TDATA_W-1:0]    s_tdata,  // level[6:0], transition_ticks[22:7]
	input  logic [sprpg_pkg::CMD_W-1:0]        s_tuser,  // command[1:0]
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sprpg_pkg::M_TDATA_W-1:0]    m_tdata   // position[11:0], power_on[12],
	                                                     // moving[13], current_level[21:14]
);
	import sprpg_pkg::*;

	dp_cmd_t                 cmd;
	dp_stat_t                stat;
	logic [POS_W-1:0]        out_position;
	logic                    out_power;
	logic                    out_moving;
	logic signed [CL_W-1:0]  out_level;

	// Sequencer.
	sprpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath with its shared divider.
	sprpg_dpath #(
		.POWER_OFF_TICKS (POWER_OFF_TICKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_cmd       (s_tuser),
		.in_level     (s_tdata[LVL_W-1:0]),
		.in_trans     (s_tdata[LVL_W+TRANS_W-1:LVL_W]),
		.cmd          (cmd),
		.stat         (stat),
		.out_position (out_position),
		.out_power    (out_power),
		.out_moving   (out_moving),
		.out_level    (out_level)
	);

	// Pack the result fields, lowest first.
	assign m_tdata = {{(M_TDATA_W - POS_W - 2 - CL_W){1'b0}},
	                  out_level, out_moving, out_power, out_position};

endmodule

>>> design/sprpg_checker.sv
// ----------------------------------------------------------------------------
// sprpg_checker
// Port-level checks on the request and result streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprpg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sprpg_pkg::M_TDATA_W-1:0]   m_tdata
);
	import sprpg_pkg::*;

	// A stalled result keeps its value.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Only one request is worked on at a time.
	`ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A result never appears in the cycle right after a request is taken.
	`ASSERT_IMPLY(a_no_instant_result, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result too early")

endmodule

bind servo_position_ramp_power_gate_core sprpg_checker u_sprpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
